// ===== rtl/gtps_pkg.sv =====
`timescale 1ns / 1ps

package gtps_pkg;

    localparam int CORDIC_STEPS = 16;

    localparam int CW = 36;
    typedef logic signed [CW-1:0] cw_t;
    typedef logic signed [19:0]   ang_t;
    typedef logic signed [24:0]   delta_t;

    typedef struct packed {
        cw_t               x;
        cw_t               y;
        ang_t              z;
        logic signed [15:0] hd;
        logic              zero;
        logic              far;
        logic              in_goal;
    } cord_t;

    localparam ang_t PI_Q13          = 20'sd25736;
    localparam ang_t TWO_PI_Q13      = 20'sd51472;
    localparam ang_t LIMIT_30DEG_Q13 = 20'sd4289;
    localparam ang_t HALF_PI_Q16     = 20'sd102944;
    localparam logic [48:0] FAR_SQ   = 49'd1000000;

    localparam logic [16:0] ATAN_Q16 [24] = '{
        17'd51472, 17'd30385, 17'd16055, 17'd8150, 17'd4091, 17'd2047, 17'd1024, 17'd512,
        17'd256, 17'd128, 17'd64, 17'd32, 17'd16, 17'd8, 17'd4, 17'd2,
        17'd1, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0
    };

    localparam logic [2:0] REG_TARGET_X    = 3'd0;
    localparam logic [2:0] REG_TARGET_Y    = 3'd1;
    localparam logic [2:0] REG_FAST_SPEED  = 3'd2;
    localparam logic [2:0] REG_SLOW_SPEED  = 3'd3;
    localparam logic [2:0] REG_ARRIVE_RAD  = 3'd4;
    localparam logic [2:0] REG_GOAL_HEAD   = 3'd5;
    localparam logic [2:0] REG_HEAD_TOL    = 3'd6;
    localparam logic [2:0] REG_MAX_ROT     = 3'd7;

    function automatic ang_t wrap_once(ang_t a);
        ang_t r;
        if (a > PI_Q13)
        begin
            r = a - TWO_PI_Q13;
        end
        else if (a <= -PI_Q13)
        begin
            r = a + TWO_PI_Q13;
        end
        else
        begin
            r = a;
        end
        return r;
    endfunction

    function automatic ang_t ang_abs(ang_t a);
        return a[19] ? -a : a;
    endfunction

    // One micro-rotation toward y = 0; the shift is arithmetic (floor).
    function automatic cord_t cordic_step(cord_t c, int unsigned k);
        cord_t r;
        cw_t   xs;
        cw_t   ys;
        ang_t  da;
        r  = c;
        xs = c.x >>> k;
        ys = c.y >>> k;
        da = ang_t'({3'b000, ATAN_Q16[k]});
        if (c.y > 0)
        begin
            r.x = c.x + ys;
            r.y = c.y - xs;
            r.z = c.z + da;
        end
        else
        begin
            r.x = c.x - ys;
            r.y = c.y + xs;
            r.z = c.z - da;
        end
        return r;
    endfunction

endpackage

// ===== rtl/go_to_point_steering.sv =====
`timescale 1ns / 1ps

// Go-to-point steering controller.
// The s_ channel takes one odometry pose per transfer; the m_ channel gives
// one velocity command per pose, in order. Target, speeds, radius, goal
// heading, tolerance and rotation limit are APB registers at byte addresses
// 0, 4, ... 28; the user must write them only while no pose is in flight;
// the block does not enforce this. From the input transfer to m_tvalid a
// pose passes one stage for the deltas, one for the squares and the quadrant
// rotation, one for the distance compares, one per CORDIC iteration, two for
// rounding and angle wrapping, and the output register.
// Throughput is one pose per cycle while m_tready is high; every stage holds
// its own valid bit. A stage loads whenever it is empty or its successor
// loads, so when the receiver stalls the pipeline fills up and bubbles close
// before s_tready drops; nothing is lost or repeated.
// Reset clears all valid bits and sets the registers to their reset values
// (tolerance and rotation limit to pi, everything else to zero).

module go_to_point_steering
    import gtps_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,  // pos_x[23:0], pos_y[47:24], heading[63:48]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,  // translation[15:0], rotation[31:16]
    output logic [0:0]  m_tuser,  // reached[0]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int N = CORDIC_STEPS;

    logic signed [23:0] target_x_reg;
    logic signed [23:0] target_y_reg;
    logic signed [15:0] fast_speed_reg;
    logic signed [15:0] slow_speed_reg;
    logic [22:0]        arrive_radius_reg;
    logic signed [15:0] goal_heading_reg;
    logic [14:0]        heading_tolerance_reg;
    logic [14:0]        max_rotation_reg;

    logic cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_x_reg          <= '0;
            target_y_reg          <= '0;
            fast_speed_reg        <= '0;
            slow_speed_reg        <= '0;
            arrive_radius_reg     <= '0;
            goal_heading_reg      <= '0;
            heading_tolerance_reg <= 15'(PI_Q13);
            max_rotation_reg      <= 15'(PI_Q13);
        end
        else if (cfg_wr)
        begin
            unique case (paddr[4:2])
                REG_TARGET_X:   target_x_reg          <= pwdata[23:0];
                REG_TARGET_Y:   target_y_reg          <= pwdata[23:0];
                REG_FAST_SPEED: fast_speed_reg        <= pwdata[15:0];
                REG_SLOW_SPEED: slow_speed_reg        <= pwdata[15:0];
                REG_ARRIVE_RAD: arrive_radius_reg     <= pwdata[22:0];
                REG_GOAL_HEAD:  goal_heading_reg      <= pwdata[15:0];
                REG_HEAD_TOL:   heading_tolerance_reg <= pwdata[14:0];
                REG_MAX_ROT:    max_rotation_reg      <= pwdata[14:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[4:2])
            REG_TARGET_X:   prdata = 32'(target_x_reg);
            REG_TARGET_Y:   prdata = 32'(target_y_reg);
            REG_FAST_SPEED: prdata = 32'(fast_speed_reg);
            REG_SLOW_SPEED: prdata = 32'(slow_speed_reg);
            REG_ARRIVE_RAD: prdata = {9'd0, arrive_radius_reg};
            REG_GOAL_HEAD:  prdata = 32'(goal_heading_reg);
            REG_HEAD_TOL:   prdata = {17'd0, heading_tolerance_reg};
            REG_MAX_ROT:    prdata = {17'd0, max_rotation_reg};
            default:        prdata = '0;
        endcase
    end

    // Stage handshake: a stage loads when it is empty or its successor loads.
    logic       a_v_reg;
    logic       b_v_reg;
    logic [N:0] cd_v_reg;
    logic       p1_v_reg;
    logic       p2_v_reg;
    logic       out_v_reg;

    logic       ld_a;
    logic       ld_b;
    logic [N:0] ld_cd;
    logic       ld_p1;
    logic       ld_p2;
    logic       ld_out;

    assign ld_out = !out_v_reg || m_tready;
    assign ld_p2  = !p2_v_reg || ld_out;
    assign ld_p1  = !p1_v_reg || ld_p2;
    assign ld_cd[N] = !cd_v_reg[N] || ld_p1;

    genvar gk;
    generate
        for (gk = 0; gk < N; gk++)
        begin : g_ld
            assign ld_cd[gk] = !cd_v_reg[gk] || ld_cd[gk+1];
        end
    endgenerate

    assign ld_b     = !b_v_reg || ld_cd[0];
    assign ld_a     = !a_v_reg || ld_b;
    assign s_tready = ld_a;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg   <= 1'b0;
            b_v_reg   <= 1'b0;
            cd_v_reg  <= '0;
            p1_v_reg  <= 1'b0;
            p2_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            if (ld_a)
            begin
                a_v_reg <= s_tvalid;
            end
            if (ld_b)
            begin
                b_v_reg <= a_v_reg;
            end
            if (ld_cd[0])
            begin
                cd_v_reg[0] <= b_v_reg;
            end
            for (int k = 1; k <= N; k++)
            begin
                if (ld_cd[k])
                begin
                    cd_v_reg[k] <= cd_v_reg[k-1];
                end
            end
            if (ld_p1)
            begin
                p1_v_reg <= cd_v_reg[N];
            end
            if (ld_p2)
            begin
                p2_v_reg <= p1_v_reg;
            end
            if (ld_out)
            begin
                out_v_reg <= p2_v_reg;
            end
        end
    end

    // Stage A: deltas to the target.
    delta_t             a_dx_reg;
    delta_t             a_dy_reg;
    logic signed [15:0] a_hd_reg;
    delta_t             a_dx_next;
    delta_t             a_dy_next;

    assign a_dx_next = delta_t'(target_x_reg) - delta_t'($signed(s_tdata[23:0]));
    assign a_dy_next = delta_t'(target_y_reg) - delta_t'($signed(s_tdata[47:24]));

    always_ff @(posedge clk)
    begin
        if (ld_a)
        begin
            a_dx_reg <= a_dx_next;
            a_dy_reg <= a_dy_next;
            a_hd_reg <= s_tdata[63:48];
        end
    end

    // Stage B: squares and quadrant pre-rotation of the scaled deltas.
    logic [47:0]        b_dx2_reg;
    logic [47:0]        b_dy2_reg;
    logic [45:0]        b_r2_reg;
    cord_t              b_c_reg;
    logic signed [49:0] dx_sq;
    logic signed [49:0] dy_sq;
    logic [45:0]        r2_next;
    cord_t              b_c_next;
    cw_t                xs8;
    cw_t                ys8;

    assign dx_sq   = a_dx_reg * a_dx_reg;
    assign dy_sq   = a_dy_reg * a_dy_reg;
    assign r2_next = arrive_radius_reg * arrive_radius_reg;
    assign xs8     = cw_t'(a_dx_reg) <<< 8;
    assign ys8     = cw_t'(a_dy_reg) <<< 8;

    always_comb
    begin
        b_c_next        = '0;
        b_c_next.hd     = a_hd_reg;
        b_c_next.zero   = (a_dx_reg == '0) && (a_dy_reg == '0);
        if (!xs8[CW-1])
        begin
            b_c_next.x = xs8;
            b_c_next.y = ys8;
            b_c_next.z = '0;
        end
        else if (!ys8[CW-1])
        begin
            b_c_next.x = ys8;
            b_c_next.y = -xs8;
            b_c_next.z = HALF_PI_Q16;
        end
        else
        begin
            b_c_next.x = -ys8;
            b_c_next.y = xs8;
            b_c_next.z = -HALF_PI_Q16;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld_b)
        begin
            b_dx2_reg <= dx_sq[47:0];
            b_dy2_reg <= dy_sq[47:0];
            b_r2_reg  <= r2_next;
            b_c_reg   <= b_c_next;
        end
    end

    // Stage C (CORDIC entry): distance compares; then one iteration per stage.
    cord_t       cd_reg [N+1];
    cord_t       cd0_next;
    logic [48:0] d2;

    assign d2 = {1'b0, b_dx2_reg} + {1'b0, b_dy2_reg};

    always_comb
    begin
        cd0_next         = b_c_reg;
        cd0_next.far     = d2 > FAR_SQ;
        cd0_next.in_goal = d2 < {3'b000, b_r2_reg};
    end

    always_ff @(posedge clk)
    begin
        if (ld_cd[0])
        begin
            cd_reg[0] <= cd0_next;
        end
    end

    generate
        for (gk = 0; gk < N; gk++)
        begin : g_cordic
            cord_t cd_next;
            assign cd_next = cordic_step(cd_reg[gk], gk);
            always_ff @(posedge clk)
            begin
                if (ld_cd[gk+1])
                begin
                    cd_reg[gk+1] <= cd_next;
                end
            end
        end
    endgenerate

    // Stage P1: round the bearing to Q13, wrap the goal heading error.
    ang_t               p1_bear_reg;
    ang_t               p1_hdiff_reg;
    logic signed [15:0] p1_hd_reg;
    logic               p1_far_reg;
    logic               p1_in_goal_reg;
    ang_t               p1_bear_next;
    ang_t               zf;

    assign zf = cd_reg[N].z;

    always_comb
    begin
        if (cd_reg[N].zero)
        begin
            p1_bear_next = '0;
        end
        else if (!zf[19])
        begin
            p1_bear_next = (zf + 20'sd4) >>> 3;
        end
        else
        begin
            p1_bear_next = -((-zf + 20'sd4) >>> 3);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld_p1)
        begin
            p1_bear_reg    <= p1_bear_next;
            p1_hdiff_reg   <= wrap_once(ang_t'(goal_heading_reg) - ang_t'(cd_reg[N].hd));
            p1_hd_reg      <= cd_reg[N].hd;
            p1_far_reg     <= cd_reg[N].far;
            p1_in_goal_reg <= cd_reg[N].in_goal;
        end
    end

    // Stage P2: bearing error and the thirty-degree test.
    ang_t p2_err_reg;
    logic p2_big_reg;
    ang_t p2_hdiff_reg;
    logic p2_far_reg;
    logic p2_in_goal_reg;
    ang_t p2_err_next;

    assign p2_err_next = wrap_once(p1_bear_reg - ang_t'(p1_hd_reg));

    always_ff @(posedge clk)
    begin
        if (ld_p2)
        begin
            p2_err_reg     <= p2_err_next;
            p2_big_reg     <= ang_abs(p2_err_next) > LIMIT_30DEG_Q13;
            p2_hdiff_reg   <= p1_hdiff_reg;
            p2_far_reg     <= p1_far_reg;
            p2_in_goal_reg <= p1_in_goal_reg;
        end
    end

    // Output stage: command selection and clamping.
    logic [31:0]        out_data_reg;
    logic               out_reached_reg;
    logic [31:0]        out_data_next;
    logic               out_reached_next;
    logic signed [15:0] speed;
    ang_t               rot;
    ang_t               max_rot;
    ang_t               tol;

    assign max_rot = ang_t'({5'b00000, max_rotation_reg});
    assign tol     = ang_t'({5'b00000, heading_tolerance_reg});

    always_comb
    begin
        speed            = p2_far_reg ? fast_speed_reg : slow_speed_reg;
        rot              = p2_err_reg;
        out_reached_next = 1'b0;
        if (p2_big_reg)
        begin
            speed = '0;
        end
        if (p2_in_goal_reg)
        begin
            if (tol >= PI_Q13 || ang_abs(p2_hdiff_reg) <= tol)
            begin
                out_reached_next = 1'b1;
            end
            else
            begin
                speed = '0;
                rot   = p2_hdiff_reg;
            end
        end
        if (rot > max_rot)
        begin
            rot = max_rot;
        end
        if (rot < -max_rot)
        begin
            rot = -max_rot;
        end
        if (out_reached_next)
        begin
            out_data_next = '0;
        end
        else
        begin
            out_data_next = {rot[15:0], speed};
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld_out)
        begin
            out_data_reg    <= out_data_next;
            out_reached_reg <= out_reached_next;
        end
    end

    assign m_tvalid   = out_v_reg;
    assign m_tdata    = out_data_reg;
    assign m_tuser[0] = out_reached_reg;

    a_reached_idle : assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata == 32'd0)
        else $error("reached command carries nonzero motion");

    a_empty_ready : assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled while output stage is empty");

    a_cordic_x_pos : assert property (@(posedge clk) disable iff (!rst_n)
        cd_v_reg[0] |-> !cd_reg[0].x[CW-1])
        else $error("CORDIC entry x is negative after quadrant rotation");

endmodule

// ===== tb/sv/go_to_point_steering_checker.sv =====
`timescale 1ns / 1ps

module go_to_point_steering_checker
    import gtps_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [63:0] s_tdata,  // pos_x[23:0], pos_y[47:24], heading[63:48]
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,  // translation[15:0], rotation[31:16]
    input  logic [0:0]  m_tuser,  // reached[0]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    input  logic        end_check,
    output int          pending,
    output int          fail_count
);

    localparam longint HALF_TURN        = 25736;
    localparam longint FULL_TURN        = 51472;
    localparam longint STEER_LIMIT      = 4289;
    localparam longint FAR_DIST_SQ      = 1000000;
    localparam longint QUARTER_TURN_Q16 = 102944;
    localparam int     PRINTED_REPORTS  = 50;

    typedef struct packed {
        logic               reached;
        logic signed [15:0] translation;
        logic signed [15:0] rotation;
    } steer_cmd_t;

    logic signed [23:0] tgt_x;
    logic signed [23:0] tgt_y;
    logic signed [15:0] fast;
    logic signed [15:0] slow;
    logic [22:0]        radius;
    logic signed [15:0] goal_hd;
    logic [14:0]        tol;
    logic [14:0]        max_rot;
    steer_cmd_t         expected_cmds[$];
    logic               leftovers_flagged = 1'b0;

    task automatic report_mismatch(input string field, input longint got, input longint want);
        if (fail_count < PRINTED_REPORTS)
            $display("%0t ns: %s: got %0d, expected %0d", $time, field, got, want);
        fail_count++;
    endtask

    function automatic longint arctan_q16(input int step);
        longint a;
        case (step)
            0: a = 51472;
            1: a = 30385;
            2: a = 16055;
            3: a = 8150;
            4: a = 4091;
            5: a = 2047;
            default: a = 65536 >>> step;
        endcase
        return a;
    endfunction

    function automatic longint wrap_half_turn(input longint a);
        longint r;
        r = a;
        if (a > HALF_TURN)
            r = a - FULL_TURN;
        else if (a <= -HALF_TURN)
            r = a + FULL_TURN;
        return r;
    endfunction

    function automatic longint abs_angle(input longint a);
        return (a < 0) ? -a : a;
    endfunction

    function automatic longint cordic_bearing(input longint dy, input longint dx);
        longint x;
        longint y;
        longint z;
        longint t;
        longint xs;
        longint ys;
        int     i;
        if (dx == 0 && dy == 0)
            return 0;
        x = dx * 256;
        y = dy * 256;
        z = 0;
        if (x < 0)
        begin
            t = x;
            if (y >= 0)
            begin
                x = y;
                y = -t;
                z = QUARTER_TURN_Q16;
            end
            else
            begin
                x = -y;
                y = t;
                z = -QUARTER_TURN_Q16;
            end
        end
        for (i = 0; i < CORDIC_STEPS && i < 24; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0)
            begin
                x = x + ys;
                y = y - xs;
                z = z + arctan_q16(i);
            end
            else
            begin
                x = x - ys;
                y = y + xs;
                z = z - arctan_q16(i);
            end
        end
        if (z >= 0)
            return (z + 4) >>> 3;
        return -((-z + 4) >>> 3);
    endfunction

    function automatic steer_cmd_t steering_command(input logic signed [23:0] px,
                                                    input logic signed [23:0] py,
                                                    input logic signed [15:0] hd);
        longint     dx;
        longint     dy;
        longint     dist_sq;
        longint     radius_sq;
        longint     err;
        longint     speed;
        longint     rot;
        longint     hdiff;
        logic       done;
        steer_cmd_t cmd;
        dx = longint'(tgt_x) - longint'(px);
        dy = longint'(tgt_y) - longint'(py);
        dist_sq = dx * dx + dy * dy;
        radius_sq = longint'(radius) * longint'(radius);
        err = wrap_half_turn(cordic_bearing(dy, dx) - longint'(hd));
        speed = (dist_sq > FAR_DIST_SQ) ? longint'(fast) : longint'(slow);
        rot = err;
        done = 1'b0;
        if (abs_angle(err) > STEER_LIMIT)
            speed = 0;
        if (dist_sq < radius_sq)
        begin
            done = (longint'(tol) >= HALF_TURN);
            if (!done)
            begin
                hdiff = wrap_half_turn(longint'(goal_hd) - longint'(hd));
                if (abs_angle(hdiff) <= longint'(tol))
                begin
                    done = 1'b1;
                end
                else
                begin
                    speed = 0;
                    rot = hdiff;
                end
            end
        end
        if (rot > longint'(max_rot))
            rot = longint'(max_rot);
        if (rot < -longint'(max_rot))
            rot = -longint'(max_rot);
        cmd.reached = done;
        cmd.translation = done ? 16'sd0 : speed[15:0];
        cmd.rotation = done ? 16'sd0 : rot[15:0];
        return cmd;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        steer_cmd_t want;
        if (!rst_n)
        begin
            tgt_x <= '0;
            tgt_y <= '0;
            fast <= '0;
            slow <= '0;
            radius <= '0;
            goal_hd <= '0;
            tol <= 15'd25736;
            max_rot <= 15'd25736;
            expected_cmds.delete();
            pending <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[4:2])
                    REG_TARGET_X:   tgt_x <= pwdata[23:0];
                    REG_TARGET_Y:   tgt_y <= pwdata[23:0];
                    REG_FAST_SPEED: fast <= pwdata[15:0];
                    REG_SLOW_SPEED: slow <= pwdata[15:0];
                    REG_ARRIVE_RAD: radius <= pwdata[22:0];
                    REG_GOAL_HEAD:  goal_hd <= pwdata[15:0];
                    REG_HEAD_TOL:   tol <= pwdata[14:0];
                    REG_MAX_ROT:    max_rot <= pwdata[14:0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready)
            begin
                if (expected_cmds.size() == 0)
                begin
                    report_mismatch("unexpected command, rotation/translation",
                                    $signed(m_tdata[31:16]), $signed(m_tdata[15:0]));
                end
                else
                begin
                    want = expected_cmds.pop_front();
                    if (m_tuser[0] !== want.reached)
                        report_mismatch("reached", m_tuser[0], want.reached);
                    if (m_tdata[15:0] !== want.translation)
                        report_mismatch("translation", $signed(m_tdata[15:0]), want.translation);
                    if (m_tdata[31:16] !== want.rotation)
                        report_mismatch("rotation", $signed(m_tdata[31:16]), want.rotation);
                end
            end
            if (s_tvalid && s_tready)
                expected_cmds.push_back(steering_command(s_tdata[23:0], s_tdata[47:24],
                                                         s_tdata[63:48]));
            if (end_check && !leftovers_flagged)
            begin
                leftovers_flagged = 1'b1;
                while (expected_cmds.size() != 0)
                begin
                    want = expected_cmds.pop_front();
                    report_mismatch("missing command, translation", 0, want.translation);
                end
            end
            pending <= expected_cmds.size();
        end
    end

endmodule

// ===== tb/sv/go_to_point_steering_tb.sv =====
`timescale 1ns / 1ps

module go_to_point_steering_tb;
    import gtps_pkg::*;

    localparam int LATENCY      = CORDIC_STEPS + 6;
    localparam int STALL_LIMIT  = 2000;
    localparam int RANDOM_POSES = 1550;
    localparam int PHASES       = 8;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        quiet;
    logic        end_check;
    int          pending;
    int          fail_count;
    int          stall_cycles = 0;

    logic signed [23:0] cur_tx;
    logic signed [23:0] cur_ty;
    int                 cur_rad;
    logic signed [15:0] cur_gh;
    int                 cur_tol;

    go_to_point_steering i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    go_to_point_steering_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .pready     (pready),
        .end_check  (end_check),
        .pending    (pending),
        .fail_count (fail_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        m_tready <= quiet || ($urandom_range(99) >= 10);
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("go_to_point_steering_tb: FAIL");
            $finish;
        end
    end

    task automatic apb_write(input logic [2:0] idx, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
    endtask

    task automatic load_settings(input logic signed [23:0] tx, input logic signed [23:0] ty,
                                 input logic signed [15:0] fs, input logic signed [15:0] ss,
                                 input int rad, input logic signed [15:0] gh,
                                 input int tol, input int mr);
        cur_tx = tx;
        cur_ty = ty;
        cur_rad = rad;
        cur_gh = gh;
        cur_tol = tol;
        apb_write(REG_TARGET_X, 32'(tx));
        apb_write(REG_TARGET_Y, 32'(ty));
        apb_write(REG_FAST_SPEED, 32'(fs));
        apb_write(REG_SLOW_SPEED, 32'(ss));
        apb_write(REG_ARRIVE_RAD, 32'(rad));
        apb_write(REG_GOAL_HEAD, 32'(gh));
        apb_write(REG_HEAD_TOL, 32'(tol));
        apb_write(REG_MAX_ROT, 32'(mr));
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_pose(input logic signed [23:0] px, input logic signed [23:0] py,
                             input logic signed [15:0] hd);
        if (!quiet && $urandom_range(99) < 4)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {hd, py, px};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic drain_commands();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic random_settings(input int phase);
        logic signed [23:0] tx;
        logic signed [23:0] ty;
        int                 rad;
        int                 tol;
        if (phase == 0)
        begin
            load_settings(-24'sd8388608, -24'sd8388608, -16'sd32768, 16'sd32767,
                          0, -16'sd25736, 0, 0);
        end
        else if (phase == 1)
        begin
            load_settings(24'sd8388607, 24'sd8388607, 16'sd32767, -16'sd32768,
                          8388607, 16'sd25736, 25736, 25736);
        end
        else
        begin
            tx = ($urandom_range(99) < 30) ? 24'($urandom) : 24'(int'($urandom_range(20000)) - 10000);
            ty = ($urandom_range(99) < 30) ? 24'($urandom) : 24'(int'($urandom_range(20000)) - 10000);
            rad = ($urandom_range(99) < 10) ? int'($urandom_range(8388607)) : int'($urandom_range(3000));
            tol = ($urandom_range(99) < 25) ? 25736 : int'($urandom_range(25736));
            load_settings(tx, ty, 16'($urandom), 16'($urandom), rad,
                          16'(int'($urandom_range(51472)) - 25736), tol,
                          int'($urandom_range(25736)));
        end
    endtask

    task automatic send_random_pose();
        int                 sel;
        int                 span;
        int                 w;
        logic signed [23:0] px;
        logic signed [23:0] py;
        logic signed [15:0] hd;
        sel = $urandom_range(99);
        span = (sel < 45) ? cur_rad + 500 : 3000;
        if (span > 100000)
            span = 100000;
        if (sel < 75)
        begin
            px = 24'(int'(cur_tx) + int'($urandom_range(2 * span)) - span);
            py = 24'(int'(cur_ty) + int'($urandom_range(2 * span)) - span);
        end
        else
        begin
            px = 24'($urandom);
            py = 24'($urandom);
        end
        sel = $urandom_range(99);
        w = cur_tol + 20;
        if (sel < 20)
            hd = 16'(int'(cur_gh) + int'($urandom_range(2 * w)) - w);
        else if (sel < 25)
            hd = 16'($urandom);
        else
            hd = 16'(int'($urandom_range(51472)) - 25736);
        send_pose(px, py, hd);
    endtask

    initial
    begin
        int p;
        int n;
        rst_n <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        quiet <= 1'b0;
        end_check <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // On target, out-of-range headings, far corners, the one-metre edge and the
        // 30 degree edge, all with the goal area switched off.
        load_settings(24'sd0, 24'sd0, 16'sd32767, -16'sd32768, 0, 16'sd0, 25736, 25736);
        send_pose(24'sd0, 24'sd0, 16'sd0);
        send_pose(24'sd0, 24'sd0, 16'sd32767);
        send_pose(24'sd0, 24'sd0, -16'sd32768);
        send_pose(-24'sd8388608, -24'sd8388608, 16'sd25736);
        send_pose(24'sd8388607, 24'sd8388607, -16'sd25736);
        send_pose(24'sd8388607, -24'sd8388608, 16'sd0);
        send_pose(-24'sd8388608, 24'sd8388607, 16'sd0);
        send_pose(24'sd1000, 24'sd0, 16'sd25736);
        send_pose(24'sd1001, 24'sd0, 16'sd25736);
        send_pose(-24'sd1000, 24'sd0, -16'sd4289);
        send_pose(-24'sd1000, 24'sd0, -16'sd4290);
        send_pose(-24'sd5000, 24'sd0, 16'sd4290);
        drain_commands();

        // Maximum goal radius with zero tolerance: reached or turning.
        load_settings(24'sd1000, -24'sd2000, 16'sd300, 16'sd100, 8388607, 16'sd25736, 0, 4000);
        send_pose(24'sd1000, -24'sd2000, 16'sd25736);
        send_pose(24'sd0, 24'sd0, -16'sd25735);
        send_pose(24'sd5, 24'sd5, 16'sd0);
        send_pose(-24'sd3, 24'sd7, -16'sd32768);
        drain_commands();

        // Orientation step off; poses on and just across the goal radius.
        load_settings(-24'sd7, 24'sd9, -16'sd500, 16'sd700, 1000, -16'sd25736, 25736, 0);
        send_pose(-24'sd7, 24'sd9, 16'sd100);
        send_pose(-24'sd7, 24'sd1008, 16'sd0);
        send_pose(-24'sd7, 24'sd1009, 16'sd0);
        send_pose(-24'sd1007, 24'sd9, 16'sd0);
        drain_commands();

        for (p = 0; p < PHASES; p++)
        begin
            random_settings(p);
            quiet <= (p == 3);
            for (n = 0; n < RANDOM_POSES / PHASES; n++)
            begin
                if (p == 5 && n == 96)
                    drain_commands();
                send_random_pose();
            end
            drain_commands();
        end

        end_check <= 1'b1;
        @(posedge clk);
        @(posedge clk);
        if (fail_count == 0)
            $display("go_to_point_steering_tb: PASS");
        else
            $display("go_to_point_steering_tb: FAIL");
        $finish;
    end

endmodule
